// File: hw/rtl/pip_pkg.sv
// Shared types and constants for the polygon classifier.
package pip_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF = 14;
  localparam int RAY_END_X_DEF = 10000;
  localparam int MIN_POLY_VERTICES = 3;
  localparam int COUNT_BITS = 7;
  localparam int INDEX_BITS = 6;
  localparam int CLASS_BITS = 2;

  localparam logic [1:0] CLASS_INVALID = 2'd0;
  localparam logic [1:0] CLASS_BOUNDARY = 2'd1;
  localparam logic [1:0] CLASS_INSIDE = 2'd2;
  localparam logic [1:0] CLASS_OUTSIDE = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch query point, clear counters
    logic step;    // evaluate one edge from the registered vertex pair
  } pip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic on_edge;
  } pip_stat_t;
endpackage

// File: hw/rtl/point_in_polygon_classifier.sv
// Flow: a query reads vertex 0 (S_RD0, S_RD1), steps the edges (S_EDGE, S_LAST), then holds
// the result in S_DONE (n = vertex_count capped at MAX_VERTICES); n < 3 goes straight to S_DONE, and
// a boundary hit ends the walk early. Throughput: one word at a time; a query blocks the input until its
// result is taken, stepping one edge per cycle from the vertex RAM read port; writes are taken in idle.
// Reset (rst, synchronous): clears controller and vertex_count; vertex RAM is
// undefined until written.
module point_in_polygon_classifier import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int RAY_END_X = RAY_END_X_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [COUNT_BITS-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [INDEX_BITS-1:0]        vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CLASS_BITS-1:0]        position_class
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int VW = 2 * COORD_BITS;

  logic [COUNT_BITS-1:0] vertex_count;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rdata, va, vb;
  logic hold_a, lat_b, we, odd_pos;
  pip_cmd_t cmd;
  pip_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= '0;
    else if (cfg_we) vertex_count <= cfg_wdata;
  end

  assign we = in_valid && in_ready && kind == KIND_WRITE &&
              32'(vertex_index) < MAX_VERTICES;

  pip_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram (
    .clk, .we, .waddr(AW'(vertex_index)), .wdata({coord_x, coord_y}),
    .raddr, .rdata
  );

  // va/vb form the edge pair; first vertex kept for the closing edge
  logic [VW-1:0] v0;
  always_ff @(posedge clk) begin
    if (hold_a) begin
      v0 <= rdata;
      va <= rdata;
    end else if (lat_b) begin
      va <= rdata;
    end
  end
  assign vb = (cmd.step && !lat_b) ? v0 : rdata;

  pip_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .vertex_count,
    .out_valid, .out_ready, .position_class, .raddr, .hold_a, .lat_b,
    .cmd, .stat, .odd_pos
  );

  pip_datapath #(.COORD_BITS(COORD_BITS), .RAY_END_X(RAY_END_X), .CNT_BITS(AW + 3)) u_dp (
    .clk, .cmd, .qx(coord_x), .qy(coord_y), .va, .vb, .stat, .odd_pos
  );
endmodule

// File: hw/rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module pip_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/pip_datapath.sv
// Edge test datapath: one polygon edge against the ray per step.
module pip_datapath import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int RAY_END_X = RAY_END_X_DEF,
  parameter int CNT_BITS = 12
) (
  input  logic                         clk,
  input  pip_cmd_t                     cmd,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic [2*COORD_BITS-1:0]      va,
  input  logic [2*COORD_BITS-1:0]      vb,
  output pip_stat_t                    stat,
  output logic                         odd_pos
);
  // 18 bits covers RAY_END_X up to 65535 plus sign; coordinate width may exceed it
  localparam int W = (COORD_BITS + 2 > 18) ? COORD_BITS + 2 : 18;
  localparam int PW = 2 * W + 2;

  logic signed [W-1:0] px, py, fx;
  logic signed [CNT_BITS-1:0] cnt;

  logic signed [W-1:0] ax, ay, bx, by;
  assign ax = W'(signed'(va[2*COORD_BITS-1:COORD_BITS]));
  assign ay = W'(signed'(va[COORD_BITS-1:0]));
  assign bx = W'(signed'(vb[2*COORD_BITS-1:COORD_BITS]));
  assign by = W'(signed'(vb[COORD_BITS-1:0]));
  assign fx = W'(RAY_END_X);

  function automatic logic [1:0] turn(input logic signed [W-1:0] x1, y1, x2, y2, x3, y3);
    logic signed [PW-1:0] v;
    v = PW'(y2 - y1) * PW'(x3 - x2) - PW'(x2 - x1) * PW'(y3 - y2);
    if (v == '0) return 2'd0;
    return (v > 0) ? 2'd1 : 2'd2;
  endfunction

  function automatic logic in_box(input logic signed [W-1:0] x1, y1, qx2, qy2, x3, y3);
    return (qx2 <= ((x1 > x3) ? x1 : x3)) && (qx2 >= ((x1 < x3) ? x1 : x3)) &&
           (qy2 <= ((y1 > y3) ? y1 : y3)) && (qy2 >= ((y1 < y3) ? y1 : y3));
  endfunction

  logic [1:0] t1, t2, t3, t4;
  logic meet, bnd, lvl;
  always_comb begin
    t1 = turn(ax, ay, bx, by, px, py);
    t2 = turn(ax, ay, bx, by, fx, py);
    t3 = turn(px, py, fx, py, ax, ay);
    t4 = turn(px, py, fx, py, bx, by);
    meet = (t1 != t2 && t3 != t4) ||
           (t1 == 2'd0 && in_box(ax, ay, px, py, bx, by)) ||
           (t2 == 2'd0 && in_box(ax, ay, fx, py, bx, by)) ||
           (t3 == 2'd0 && in_box(px, py, ax, ay, fx, py)) ||
           (t4 == 2'd0 && in_box(px, py, bx, by, fx, py));
    bnd = meet && (turn(ax, ay, px, py, bx, by) == 2'd0) &&
          in_box(ax, ay, px, py, bx, by);
    lvl = (ay == py);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px <= W'(qx);
      py <= W'(qy);
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + CNT_BITS'(meet) - CNT_BITS'(lvl);
    end
  end

  assign stat.on_edge = cmd.step && bnd;
  assign odd_pos = (cnt > 0) && cnt[0];
endmodule

// File: hw/rtl/pip_ctrl.sv
// Controller: sequences vertex reads and edge steps for one query.
module pip_ctrl import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [COUNT_BITS-1:0]           vertex_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      position_class,
  output logic [$clog2(MAX_VERTICES)-1:0] raddr,
  output logic                            hold_a,
  output logic                            lat_b,
  output pip_cmd_t                        cmd,
  input  pip_stat_t                       stat,
  input  logic                            odd_pos
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = AW + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_RD0 = 3'd1, S_RD1 = 3'd2,
                         S_EDGE = 3'd3, S_LAST = 3'd4, S_DONE = 3'd5;

  logic [2:0] state, state_next;
  logic [NW-1:0] n, n_next, i, i_next;
  logic [1:0] res, res_next;
  logic full;

  always_comb begin
    // clamp count to the store
    if (32'(vertex_count) > MAX_VERTICES) n_next = NW'(MAX_VERTICES);
    else n_next = NW'(vertex_count);
  end

  assign full = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !full;
  assign out_valid = (state == S_DONE);
  // count is final and held while DONE, so the odd-crossing test resolves here
  assign position_class = (res == CLASS_OUTSIDE && odd_pos) ? CLASS_INSIDE : res;

  always_comb begin
    state_next = state;
    i_next = i;
    res_next = res;
    cmd = '0;
    hold_a = 1'b0;
    lat_b = 1'b0;
    raddr = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready && kind == KIND_QUERY) begin
        cmd.start = 1'b1;
        if (32'(n_next) < MIN_POLY_VERTICES) begin
          res_next = CLASS_INVALID;
          state_next = S_DONE;
        end else begin
          state_next = S_RD0;
        end
        i_next = '0;
      end
      // read slot 0: held as first vertex and pair start
      S_RD0: begin
        raddr = '0;
        state_next = S_RD1;
        i_next = NW'(1);
      end
      S_RD1: begin
        hold_a = 1'b1;
        raddr = i[AW-1:0];
        state_next = S_EDGE;
      end
      S_EDGE: begin
        // vb holds vertex i; va holds vertex i-1
        cmd.step = 1'b1;
        lat_b = 1'b1;
        if (stat.on_edge) begin
          res_next = CLASS_BOUNDARY;
          state_next = S_DONE;
        end else if (i + 1'b1 == n) begin
          state_next = S_LAST;
        end else begin
          i_next = i + 1'b1;
          raddr = i_next[AW-1:0];
        end
      end
      S_LAST: begin
        // closing edge: last vertex back to first
        cmd.step = 1'b1;
        if (stat.on_edge) res_next = CLASS_BOUNDARY;
        else res_next = CLASS_OUTSIDE;
        state_next = S_DONE;
      end
      S_DONE: if (out_ready) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      n <= '0;
      res <= CLASS_INVALID;
    end else begin
      state <= state_next;
      i <= i_next;
      if (cmd.start) n <= n_next;
      res <= res_next;
    end
  end
endmodule
